### rtl/kmpfm_pkg.sv
// Shared constants for the first-match string search block.
package kmpfm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    localparam logic [POS_W-1:0] POS_LIMIT = 16'hFFFF;

    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

endpackage

### rtl/kmpfm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module kmpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/kmp_first_match_search_top.sv
// Top level of the first-match string search block with its sequencer and state.
//
// Usage:
// Items enter on the s_ channel. s_tuser selects the kind: a pattern byte or a
// text byte. Pattern bytes are loaded from index 0 upward; each load stores the
// byte and builds its failure entry. Text bytes are matched one per item. The
// first full match gives one item on the m_ channel with found set and the
// start position; a text that ends (s_tlast) without a match gives one item
// with found clear. cfg_we writes the pattern length; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// After the accept cycle a walk compares the byte and follows failure links,
// reading both memories in parallel once per cycle. Pattern loads at index 0
// and text bytes after a match need no walk.
// m_tvalid rises at the edge that ends the walk. A
// result waiting in the output register does not block new items; only a walk
// that ends with a new result while the old one is still held waits for
// m_tready. Synchronous reset clears the search state and sets the pattern
// length to 1; the memories keep their contents and are defined only where
// written.
module kmp_first_match_search_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [kmpfm_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // char_value [7:0], char_index [13:8], zero [15:14]
    input  logic [kmpfm_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                        s_tuser,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // position [15:0]
    output logic [kmpfm_pkg::POS_W-1:0] m_tdata,
    // found [0], too_long [1]
    output logic [kmpfm_pkg::M_TUSER_W-1:0] m_tuser
);
    import kmpfm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic              state_reg, state_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              is_text_reg, is_text_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  build_len_reg, build_len_next;
    logic [LEN_W-1:0]  text_len_reg, text_len_next;
    logic [POS_W-1:0]  text_pos_reg, text_pos_next;
    logic              match_done_reg, match_done_next;
    logic              sat_reg, sat_next;
    logic [LEN_W-1:0]  pat_len_reg, pat_len_next;
    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic              m_found_reg, m_found_next;
    logic              m_long_reg, m_long_next;

    logic              s_accept;
    logic [CHAR_W-1:0] in_char;
    logic [IDX_W-1:0]  in_idx;
    logic [LEN_W-1:0]  used_len;
    logic [IDX_W-1:0]  text_j0, pat_j0, j_start, rd_j;
    logic              pat_we, fail_we;
    logic [IDX_W-1:0]  pat_waddr, fail_waddr, fail_wdata;
    logic [CHAR_W-1:0] pat_rdata;
    logic [IDX_W-1:0]  fail_rdata;
    logic              hit, step, is_match, emit, out_busy, pos_top;
    logic [LEN_W-1:0]  j_final;
    logic [POS_W:0]    pos_plus, start_pos;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_char  = s_tdata[CHAR_W-1:0];
    assign in_idx   = s_tdata[CHAR_W+IDX_W-1:CHAR_W];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pos_reg;
    assign m_tuser  = {m_long_reg, m_found_reg};

    always_comb begin
        if (pat_len_reg == '0) begin
            used_len = LEN_W'(1);
        end else if (pat_len_reg > LEN_W'(MAX_PATTERN)) begin
            used_len = LEN_W'(MAX_PATTERN);
        end else begin
            used_len = pat_len_reg;
        end
    end

    assign text_j0 = (text_len_reg >= used_len) ? '0 : text_len_reg[IDX_W-1:0];
    assign pat_j0  = (build_len_reg >= in_idx) ? '0 : build_len_reg;
    assign j_start = (s_tuser == REQ_TEXT) ? text_j0 : pat_j0;

    assign hit      = (pat_rdata == char_reg);
    assign step     = (j_reg != '0) && !hit;
    assign j_final  = {1'b0, j_reg} + LEN_W'(hit);
    assign is_match = (j_final >= used_len);
    assign emit     = is_match || last_reg;
    assign out_busy = m_valid_reg && !m_tready;
    assign pos_top  = (text_pos_reg == POS_LIMIT);
    assign pos_plus = {1'b0, text_pos_reg} + (POS_W+1)'(1);
    assign start_pos = pos_plus - (POS_W+1)'(used_len);

    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_j = j_start;
        end else if (step) begin
            rd_j = fail_rdata;
        end else begin
            rd_j = j_reg;
        end
    end

    assign pat_we     = s_accept && (s_tuser == REQ_PATTERN);
    assign pat_waddr  = in_idx;

    always_comb begin
        fail_we    = 1'b0;
        fail_waddr = idx_reg;
        fail_wdata = j_final[IDX_W-1:0];
        if (pat_we && (in_idx == '0)) begin
            fail_we    = 1'b1;
            fail_waddr = '0;
            fail_wdata = '0;
        end else if ((state_reg == ST_WALK) && !step && !is_text_reg) begin
            fail_we = 1'b1;
        end
    end

    kmpfm_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (in_char),
        .raddr (rd_j),
        .rdata (pat_rdata)
    );

    kmpfm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_failure_ram (
        .aclk  (aclk),
        .we    (fail_we),
        .waddr (fail_waddr),
        .wdata (fail_wdata),
        .raddr (rd_j - IDX_W'(1)),
        .rdata (fail_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        j_next          = j_reg;
        char_next       = char_reg;
        idx_next        = idx_reg;
        is_text_next    = is_text_reg;
        last_next       = last_reg;
        build_len_next  = build_len_reg;
        text_len_next   = text_len_reg;
        text_pos_next   = text_pos_reg;
        match_done_next = match_done_reg;
        sat_next        = sat_reg;
        pat_len_next    = pat_len_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_pos_next      = m_pos_reg;
        m_found_next    = m_found_reg;
        m_long_next     = m_long_reg;

        if (cfg_we) begin
            pat_len_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    char_next    = in_char;
                    idx_next     = in_idx;
                    is_text_next = s_tuser;
                    last_next    = s_tlast;
                    j_next       = j_start;
                    if (s_tuser == REQ_PATTERN) begin
                        if (in_idx == '0) begin
                            build_len_next = '0;
                        end else begin
                            state_next = ST_WALK;
                        end
                    end else if (match_done_reg) begin
                        if (s_tlast) begin
                            text_len_next   = '0;
                            text_pos_next   = '0;
                            match_done_next = 1'b0;
                            sat_next        = 1'b0;
                        end
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (step) begin
                    j_next = fail_rdata;
                end else if (!is_text_reg) begin
                    build_len_next = j_final[IDX_W-1:0];
                    state_next     = ST_IDLE;
                end else if (!(emit && out_busy)) begin
                    state_next = ST_IDLE;
                    if (pos_top) begin
                        sat_next = 1'b1;
                    end else begin
                        text_pos_next = pos_plus[POS_W-1:0];
                    end
                    if (is_match) begin
                        match_done_next = 1'b1;
                        text_len_next   = '0;
                    end else begin
                        text_len_next = j_final;
                    end
                    if (emit) begin
                        m_valid_next = 1'b1;
                        m_found_next = is_match;
                        m_long_next  = sat_reg || pos_top;
                        if (is_match && (pos_plus >= (POS_W+1)'(used_len))) begin
                            m_pos_next = start_pos[POS_W-1:0];
                        end else begin
                            m_pos_next = '0;
                        end
                    end
                    if (last_reg) begin
                        text_len_next   = '0;
                        text_pos_next   = '0;
                        match_done_next = 1'b0;
                        sat_next        = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            build_len_reg  <= '0;
            text_len_reg   <= '0;
            text_pos_reg   <= '0;
            match_done_reg <= 1'b0;
            sat_reg        <= 1'b0;
            pat_len_reg    <= LEN_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            build_len_reg  <= build_len_next;
            text_len_reg   <= text_len_next;
            text_pos_reg   <= text_pos_next;
            match_done_reg <= match_done_next;
            sat_reg        <= sat_next;
            pat_len_reg    <= pat_len_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg       <= j_next;
        char_reg    <= char_next;
        idx_reg     <= idx_next;
        is_text_reg <= is_text_next;
        last_reg    <= last_next;
        m_pos_reg   <= m_pos_next;
        m_found_reg <= m_found_next;
        m_long_reg  <= m_long_next;
    end

endmodule

### rtl/kmpfm_checker.sv
// Port-level checks for the first-match string search block, bound to its top level.
module kmpfm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [kmpfm_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [kmpfm_pkg::POS_W-1:0]      m_tdata,
    input logic [kmpfm_pkg::M_TUSER_W-1:0]  m_tuser
);
    import kmpfm_pkg::*;

    logic pat_walk_accept;

    assign pat_walk_accept = s_tvalid && s_tready && (s_tuser == REQ_PATTERN)
        && (s_tdata[CHAR_W+IDX_W-1:CHAR_W] != '0);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_not_found_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("not-found result with nonzero position");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed or dropped");

    a_pattern_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pat_walk_accept |=> !s_tready)
        else $error("pattern load with nonzero index did not start a walk");

    a_pattern_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pat_walk_accept |=> !$rose(m_tvalid))
        else $error("pattern load produced a result");

endmodule

bind kmp_first_match_search_top kmpfm_checker u_kmpfm_checker (.*);
